// ===== design/lhmm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lhmm_pkg;

  localparam int NUM_BINS_DEF = 1024;
  // Wide enough for a bin index at the largest allowed bin count.
  localparam int BIN_MAX_W = 16;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [2:0] OP_ADD      = 3'd0;
  localparam logic [2:0] OP_CLEAR    = 3'd1;
  localparam logic [2:0] OP_READ     = 3'd2;
  localparam logic [2:0] OP_OUTLIERS = 3'd3;
  localparam logic [2:0] OP_MEDIAN   = 3'd4;
  localparam logic [2:0] OP_MEAN     = 3'd5;

  localparam logic [1:0] ERR_OK        = 2'd0;
  localparam logic [1:0] ERR_ZERO_TIME = 2'd1;
  localparam logic [1:0] ERR_EMPTY     = 2'd2;

  localparam logic [2:0] K_RESP   = 3'd0;
  localparam logic [2:0] K_ADD    = 3'd1;
  localparam logic [2:0] K_CLEAR  = 3'd2;
  localparam logic [2:0] K_READ   = 3'd3;
  localparam logic [2:0] K_MEDIAN = 3'd4;
  localparam logic [2:0] K_MEAN   = 3'd5;

  typedef struct packed {
    logic [2:0]  operation;
    logic [30:0] time_value;
    logic [15:0] mean_scale;
  } in_t;

  typedef struct packed {
    logic [31:0] result_value;
    logic [1:0]  error_code;
  } out_t;

  typedef struct packed {
    logic [2:0]           kind;
    logic [BIN_MAX_W-1:0] bin;
    logic [15:0]          scale;
    logic [1:0]           err;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

`default_nettype wire

// ===== design/latency_histogram_median_mean.sv =====
// Channel  | Ports                        | Accepted when
// ---------+------------------------------+------------------------
// input    | in_push, in_full, in_data    | in_push && !in_full
// result   | out_empty, out_pop, out_data | out_pop && !out_empty
//
// Add reads a bin and writes it back incremented; clear sweeps every bin; mean
// forms two 32x16 partial products, then runs a 64-step shift-subtract
// divider; median reads bins from bin 1 upward, a read state and a compare state
// per bin, through the registered read port of the bin memory. A four-item
// queue sits between the decoder and the executing engine. After reset the
// engine clears the bin memory with in_full high. Results wait in one output
// register; the engine takes no new item while it is occupied.
`timescale 1ns / 1ps
`default_nettype none

module latency_histogram_median_mean #(
  parameter int NUM_BINS = lhmm_pkg::NUM_BINS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  output logic                in_full,
  input  wire lhmm_pkg::in_t  in_data,
  output logic                out_empty,
  input  wire logic           out_pop,
  output lhmm_pkg::out_t      out_data
);

  lhmm_pkg::back_status_t status;
  lhmm_pkg::cmd_t         q_cmd;
  logic                   q_valid, q_pop;

  lhmm_front #(.NUM_BINS(NUM_BINS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_data (in_data),
    .status  (status),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  lhmm_back #(.NUM_BINS(NUM_BINS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .q_pop     (q_pop),
    .status    (status),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// ===== design/lhmm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lhmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== design/lhmm_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lhmm_front #(
  parameter int NUM_BINS = lhmm_pkg::NUM_BINS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire lhmm_pkg::in_t         in_data,
  input  wire lhmm_pkg::back_status_t status,
  output logic                       q_valid,
  output lhmm_pkg::cmd_t             q_cmd,
  input  wire logic                  q_pop
);

  localparam int PW = $clog2(lhmm_pkg::QUEUE_DEPTH);

  lhmm_pkg::cmd_t cmd;
  lhmm_pkg::cmd_t q_r [lhmm_pkg::QUEUE_DEPTH];
  logic [PW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PW:0]   cnt_r, cnt_nxt;
  logic          in_range, push_ok, pop_ok;

  always_comb begin
    in_range  = {1'b0, in_data.time_value} < 32'(NUM_BINS);
    cmd.kind  = lhmm_pkg::K_RESP;
    cmd.bin   = in_range ? in_data.time_value[lhmm_pkg::BIN_MAX_W-1:0] : '0;
    cmd.scale = in_data.mean_scale;
    cmd.err   = lhmm_pkg::ERR_OK;
    case (in_data.operation)
      lhmm_pkg::OP_ADD: begin
        if (in_data.time_value == '0) begin
          cmd.err = lhmm_pkg::ERR_ZERO_TIME;
        end else begin
          cmd.kind = lhmm_pkg::K_ADD;
        end
      end
      lhmm_pkg::OP_CLEAR: cmd.kind = lhmm_pkg::K_CLEAR;
      lhmm_pkg::OP_READ: begin
        if (in_data.time_value == '0) begin
          cmd.err = lhmm_pkg::ERR_ZERO_TIME;
        end else if (in_range) begin
          cmd.kind = lhmm_pkg::K_READ;
        end
      end
      lhmm_pkg::OP_OUTLIERS: begin
        cmd.kind = lhmm_pkg::K_READ;
        cmd.bin  = '0;
      end
      lhmm_pkg::OP_MEDIAN: cmd.kind = lhmm_pkg::K_MEDIAN;
      lhmm_pkg::OP_MEAN:   cmd.kind = lhmm_pkg::K_MEAN;
      default: cmd.kind = lhmm_pkg::K_RESP;
    endcase
  end

  // No items enter while the back end sweeps the bin memory.
  assign in_full = (cnt_r == (PW+1)'(lhmm_pkg::QUEUE_DEPTH)) || status.clearing;
  assign push_ok = in_push && !in_full;
  assign q_valid = cnt_r != '0;
  assign pop_ok  = q_pop && q_valid;
  assign q_cmd   = q_r[rp_r];

  always_comb begin
    wp_nxt  = push_ok ? wp_r + 1'b1 : wp_r;
    rp_nxt  = pop_ok ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PW+1)'(push_ok) - (PW+1)'(pop_ok);
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      q_r[wp_r] <= cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lhmm_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lhmm_back #(
  parameter int NUM_BINS = lhmm_pkg::NUM_BINS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire lhmm_pkg::cmd_t         q_cmd,
  output logic                        q_pop,
  output lhmm_pkg::back_status_t      status,
  output logic                        out_empty,
  input  wire logic                   out_pop,
  output lhmm_pkg::out_t              out_data
);

  localparam int BIN_W = $clog2(NUM_BINS);
  localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_RD   = 4'd3;
  localparam logic [3:0] S_MRD  = 4'd4;
  localparam logic [3:0] S_MCMP = 4'd5;
  localparam logic [3:0] S_MUL0 = 4'd6;
  localparam logic [3:0] S_MUL1 = 4'd7;
  localparam logic [3:0] S_DIV  = 4'd8;

  logic [3:0]       state_r, state_nxt;
  logic [BIN_W-1:0] addr_r, addr_nxt;
  logic             clr_emit_r, clr_emit_nxt;
  logic [63:0]      total_r, total_nxt, wsum_r, wsum_nxt;
  logic [63:0]      rem_r, rem_nxt, quot_r, quot_nxt;
  logic [15:0]      scale_r, scale_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  lhmm_pkg::out_t   out_r, out_nxt;

  logic             we;
  logic [BIN_W-1:0] raddr;
  logic [31:0]      wdata, rdata;
  logic             emit;
  logic [31:0]      emit_val;
  logic [1:0]       emit_err;
  logic [63:0]      bin64;
  logic [47:0]      part;
  logic [64:0]      sh;
  logic             qbit;

  lhmm_ram #(.WIDTH(32), .DEPTH(NUM_BINS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (addr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    addr_nxt     = addr_r;
    clr_emit_nxt = clr_emit_r;
    total_nxt    = total_r;
    wsum_nxt     = wsum_r;
    rem_nxt      = rem_r;
    quot_nxt     = quot_r;
    scale_nxt    = scale_r;
    cnt_nxt      = cnt_r;
    we           = 1'b0;
    wdata        = '0;
    raddr        = addr_r;
    q_pop        = 1'b0;
    emit         = 1'b0;
    emit_val     = '0;
    emit_err     = lhmm_pkg::ERR_OK;
    bin64        = 64'(addr_r);
    part         = '0;
    sh           = {rem_r, quot_r[63]};
    qbit         = 1'b0;
    case (state_r)
      S_CLR: begin
        we = 1'b1;
        if (addr_r == LAST_BIN) begin
          emit      = clr_emit_r;
          state_nxt = S_IDLE;
        end else begin
          addr_nxt = addr_r + 1'b1;
        end
      end
      S_IDLE: begin
        // A command is taken only with the result slot free, so its result
        // always has a place to land.
        if (q_valid && !out_valid_r) begin
          q_pop    = 1'b1;
          addr_nxt = q_cmd.bin[BIN_W-1:0];
          raddr    = q_cmd.bin[BIN_W-1:0];
          case (q_cmd.kind)
            lhmm_pkg::K_ADD:  state_nxt = S_ADD;
            lhmm_pkg::K_READ: state_nxt = S_RD;
            lhmm_pkg::K_CLEAR: begin
              addr_nxt     = '0;
              clr_emit_nxt = 1'b1;
              total_nxt    = '0;
              wsum_nxt     = '0;
              state_nxt    = S_CLR;
            end
            lhmm_pkg::K_MEDIAN: begin
              rem_nxt   = (total_r + 64'd1) >> 1;
              addr_nxt  = BIN_W'(1);
              state_nxt = S_MRD;
            end
            lhmm_pkg::K_MEAN: begin
              scale_nxt = q_cmd.scale;
              if (total_r == '0) begin
                emit     = 1'b1;
                emit_err = lhmm_pkg::ERR_EMPTY;
              end else begin
                state_nxt = S_MUL0;
              end
            end
            default: begin
              emit     = 1'b1;
              emit_err = q_cmd.err;
            end
          endcase
        end
      end
      S_ADD: begin
        we    = 1'b1;
        wdata = rdata + 32'd1;
        // A wrapping counter drops from all ones to zero.
        if (rdata == 32'hFFFF_FFFF) begin
          total_nxt = total_r - 64'h0000_0000_FFFF_FFFF;
          wsum_nxt  = wsum_r - (bin64 << 32) + bin64;
        end else begin
          total_nxt = total_r + 64'd1;
          wsum_nxt  = wsum_r + bin64;
        end
        emit      = 1'b1;
        state_nxt = S_IDLE;
      end
      S_RD: begin
        emit      = 1'b1;
        emit_val  = rdata;
        state_nxt = S_IDLE;
      end
      S_MRD: state_nxt = S_MCMP;
      S_MCMP: begin
        if ({32'd0, rdata} > rem_r) begin
          emit      = 1'b1;
          emit_val  = 32'(addr_r);
          state_nxt = S_IDLE;
        end else begin
          rem_nxt = rem_r - {32'd0, rdata};
          if (addr_r == LAST_BIN) begin
            emit      = 1'b1;
            state_nxt = S_IDLE;
          end else begin
            addr_nxt  = addr_r + 1'b1;
            state_nxt = S_MRD;
          end
        end
      end
      S_MUL0: begin
        part      = wsum_r[31:0] * scale_r;
        quot_nxt  = 64'(part);
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        part      = wsum_r[63:32] * scale_r;
        quot_nxt  = quot_r + {part[31:0], 32'd0};
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sh >= {1'b0, total_r}) begin
          qbit    = 1'b1;
          rem_nxt = 64'(sh - {1'b0, total_r});
        end else begin
          rem_nxt = sh[63:0];
        end
        quot_nxt = {quot_r[62:0], qbit};
        cnt_nxt  = cnt_r + 1'b1;
        if (cnt_r == 6'd63) begin
          emit      = 1'b1;
          emit_val  = quot_nxt[31:0];
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r && !out_pop;
    out_nxt       = out_r;
    if (emit) begin
      out_valid_nxt        = 1'b1;
      out_nxt.result_value = emit_val;
      out_nxt.error_code   = emit_err;
    end
  end

  assign status.clearing = state_r == S_CLR;
  assign out_empty       = !out_valid_r;
  assign out_data        = out_r;

  always_ff @(posedge clk) begin
    rem_r   <= rem_nxt;
    quot_r  <= quot_nxt;
    scale_r <= scale_nxt;
    cnt_r   <= cnt_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      addr_r      <= '0;
      clr_emit_r  <= 1'b0;
      total_r     <= '0;
      wsum_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      total_r     <= total_nxt;
      wsum_r      <= wsum_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/lhmm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lhmm_checker (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_full,
  input wire logic           out_empty,
  input wire logic           out_pop,
  input wire lhmm_pkg::out_t out_data
);

  // The memory sweep after reset must hold off new items.
  a_full_after_reset: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input not held off after reset");

  a_empty_after_reset: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result shown right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("waiting result changed");

  // Every error carries a zero value.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.error_code != lhmm_pkg::ERR_OK
      |-> out_data.result_value == 32'd0)
    else $error("error result with nonzero value");

  a_error_code: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_data.error_code != 2'd3)
    else $error("undefined error code");

endmodule

bind latency_histogram_median_mean lhmm_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

`default_nettype wire
